>>> hdl/cbez_pkg.sv
// Shared widths, register indexes, pipeline stage numbers and arithmetic helpers.
`timescale 1ns / 1ps
`default_nettype none

package cbez_pkg;

    localparam int T_FRAC_BITS = 16;
    localparam int COORD_BITS  = 32;

    localparam int T_W    = T_FRAC_BITS + 1;
    localparam int D_W    = COORD_BITS + 1;
    localparam int E_W    = COORD_BITS + 2;
    localparam int F_W    = COORD_BITS + 3;
    localparam int VEL_W  = COORD_BITS + 3;
    localparam int ACC_W  = COORD_BITS + 5;
    localparam int PM_D_W = D_W + T_W;
    localparam int PM_E_W = E_W + T_W;
    localparam int PROD_W = F_W + T_W;
    localparam int RND_W  = PROD_W - T_FRAC_BITS;

    localparam logic [T_W-1:0] T_ONE = T_W'(2 ** T_FRAC_BITS);

    localparam logic signed [PROD_W-1:0] RND_HALF    = PROD_W'(2 ** (T_FRAC_BITS - 1));
    localparam logic signed [PROD_W-1:0] RND_HALF_DN = PROD_W'(2 ** (T_FRAC_BITS - 1) - 1);

    localparam int CFG_NUM   = 8;
    localparam int CFG_IDX_W = $clog2(CFG_NUM);

    localparam logic [CFG_IDX_W-1:0] REG_P0_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_P0_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_P1_X = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_P1_Y = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_P2_X = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_P2_Y = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_P3_X = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_P3_Y = CFG_IDX_W'(7);

    localparam int S_IN  = 0;
    localparam int S_M1  = 1;
    localparam int S_R1  = 2;
    localparam int S_A1  = 3;
    localparam int S_D2  = 4;
    localparam int S_M2  = 5;
    localparam int S_R2  = 6;
    localparam int S_A2  = 7;
    localparam int S_D3  = 8;
    localparam int S_M3  = 9;
    localparam int S_R3  = 10;
    localparam int S_A3  = 11;
    localparam int S_OUT = 12;
    localparam int NSTG  = 13;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [D_W-1:0]        t_diff1;
    typedef logic signed [E_W-1:0]        t_diff2;
    typedef logic signed [F_W-1:0]        t_diff3;
    typedef logic [T_W-1:0]               t_param;
    typedef logic [NSTG-1:0]              t_stage_en;

    function automatic logic signed [PROD_W-1:0] mul_t(
        input logic signed [F_W-1:0] x,
        input logic [T_W-1:0]        t
    );
        logic signed [T_W:0] ts;
        ts = $signed({1'b0, t});
        return x * ts;
    endfunction

    function automatic logic signed [RND_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sum;
        sum = p + (p[PROD_W-1] ? RND_HALF_DN : RND_HALF);
        return sum[PROD_W-1:T_FRAC_BITS];
    endfunction

endpackage

`default_nettype wire

>>> hdl/cbez_axis.sv
// Datapath for one coordinate axis: three pipelined levels of linear interpolation.
`timescale 1ns / 1ps
`default_nettype none

module cbez_axis (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire cbez_pkg::t_stage_en        i_ce,
    input  wire cbez_pkg::t_param           i_t,
    input  wire cbez_pkg::t_coord           i_ctrl [4],
    output logic signed [cbez_pkg::COORD_BITS-1:0] o_pos,
    output logic signed [cbez_pkg::VEL_W-1:0]      o_vel,
    output logic signed [cbez_pkg::ACC_W-1:0]      o_acc
);
    import cbez_pkg::*;

    t_diff1 r_d [3];
    t_diff2 r_e [2];
    t_diff3 r_f;

    t_param r_t0, r_t1, r_t2, r_t3, r_t4, r_t5, r_t6, r_t7, r_t8;

    logic signed [PM_D_W-1:0] r_p1 [3];
    t_diff1                   r_s1 [3];
    t_coord                   r_a  [3];

    t_diff1                   r_g2  [2];
    t_coord                   r_a4  [2];
    t_coord                   r_a5  [2];
    t_coord                   r_a6  [2];
    logic signed [PM_D_W-1:0] r_p2  [2];
    logic signed [PM_E_W-1:0] r_pv2 [2];
    t_diff1                   r_s2  [2];
    t_diff2                   r_sv2 [2];
    t_coord                   r_b   [2];
    t_diff1                   r_q   [2];

    t_diff1                   r_g3, r_s3;
    t_diff2                   r_gv3, r_sv3;
    t_coord                   r_b8, r_b9, r_b10;
    t_diff1                   r_q8, r_q9, r_q10;
    logic signed [PM_D_W-1:0] r_p3;
    logic signed [PM_E_W-1:0] r_pv3;
    logic signed [PROD_W-1:0] r_pa3;
    t_diff3                   r_sa3;

    t_coord                   r_pos;
    t_diff1                   r_vq;
    t_diff2                   r_ac;

    t_coord                   r_pos_o;
    logic signed [VEL_W-1:0]  r_vel_o;
    logic signed [ACC_W-1:0]  r_acc_o;

    // Control-point differences. The user must change the control points only while the block is idle. Not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                r_e[i] <= '0;
            end
            r_f <= '0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= D_W'(i_ctrl[i+1]) - D_W'(i_ctrl[i]);
            end
            for (int i = 0; i < 2; i++) begin
                r_e[i] <= E_W'(r_d[i+1]) - E_W'(r_d[i]);
            end
            r_f <= F_W'(r_e[1]) - F_W'(r_e[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[S_IN]) begin
            r_t0 <= i_t;
        end
        if (i_ce[S_M1]) begin
            for (int i = 0; i < 3; i++) begin
                r_p1[i] <= PM_D_W'(mul_t(F_W'(r_d[i]), r_t0));
            end
            r_t1 <= r_t0;
        end
        if (i_ce[S_R1]) begin
            for (int i = 0; i < 3; i++) begin
                r_s1[i] <= D_W'(round_q(PROD_W'(r_p1[i])));
            end
            r_t2 <= r_t1;
        end
        if (i_ce[S_A1]) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= COORD_BITS'(D_W'(i_ctrl[i]) + r_s1[i]);
            end
            r_t3 <= r_t2;
        end
        if (i_ce[S_D2]) begin
            for (int j = 0; j < 2; j++) begin
                r_g2[j] <= D_W'(r_a[j+1]) - D_W'(r_a[j]);
                r_a4[j] <= r_a[j];
            end
            r_t4 <= r_t3;
        end
        if (i_ce[S_M2]) begin
            for (int j = 0; j < 2; j++) begin
                r_p2[j]  <= PM_D_W'(mul_t(F_W'(r_g2[j]), r_t4));
                r_pv2[j] <= PM_E_W'(mul_t(F_W'(r_e[j]), r_t4));
                r_a5[j]  <= r_a4[j];
            end
            r_t5 <= r_t4;
        end
        if (i_ce[S_R2]) begin
            for (int j = 0; j < 2; j++) begin
                r_s2[j]  <= D_W'(round_q(PROD_W'(r_p2[j])));
                r_sv2[j] <= E_W'(round_q(PROD_W'(r_pv2[j])));
                r_a6[j]  <= r_a5[j];
            end
            r_t6 <= r_t5;
        end
        if (i_ce[S_A2]) begin
            for (int j = 0; j < 2; j++) begin
                r_b[j] <= COORD_BITS'(D_W'(r_a6[j]) + r_s2[j]);
                r_q[j] <= D_W'(E_W'(r_d[j]) + r_sv2[j]);
            end
            r_t7 <= r_t6;
        end
        if (i_ce[S_D3]) begin
            r_g3  <= D_W'(r_b[1]) - D_W'(r_b[0]);
            r_gv3 <= E_W'(r_q[1]) - E_W'(r_q[0]);
            r_b8  <= r_b[0];
            r_q8  <= r_q[0];
            r_t8  <= r_t7;
        end
        if (i_ce[S_M3]) begin
            r_p3  <= PM_D_W'(mul_t(F_W'(r_g3), r_t8));
            r_pv3 <= PM_E_W'(mul_t(F_W'(r_gv3), r_t8));
            r_pa3 <= mul_t(r_f, r_t8);
            r_b9  <= r_b8;
            r_q9  <= r_q8;
        end
        if (i_ce[S_R3]) begin
            r_s3  <= D_W'(round_q(PROD_W'(r_p3)));
            r_sv3 <= E_W'(round_q(PROD_W'(r_pv3)));
            r_sa3 <= F_W'(round_q(r_pa3));
            r_b10 <= r_b9;
            r_q10 <= r_q9;
        end
        if (i_ce[S_A3]) begin
            r_pos <= COORD_BITS'(D_W'(r_b10) + r_s3);
            r_vq  <= D_W'(E_W'(r_q10) + r_sv3);
            r_ac  <= E_W'(F_W'(r_e[0]) + r_sa3);
        end
        if (i_ce[S_OUT]) begin
            r_pos_o <= r_pos;
            r_vel_o <= VEL_W'(r_vq) + (VEL_W'(r_vq) <<< 1);
            r_acc_o <= (ACC_W'(r_ac) <<< 2) + (ACC_W'(r_ac) <<< 1);
        end
    end

    assign o_pos = r_pos_o;
    assign o_vel = r_vel_o;
    assign o_acc = r_acc_o;

endmodule

`default_nettype wire

>>> hdl/cubic_bezier_evaluator_core.sv
// Top level of the cubic Bezier evaluator: control-point registers, valid pipeline, two axes.
//
// The four control points are written through the configuration port (write enable,
// register index, 32-bit data), one coordinate per register; the user must write them only
// while no item is in flight, as the block does not enforce it. Each input item carries a
// curve parameter in unsigned Q1.16; values above 1.0 are treated as 1.0. Each item yields
// one result: the point in signed Q16.16, first derivative Q19.16, second derivative Q21.16.
// The datapath is a 13-stage pipeline, three levels of interpolation of four stages each
// plus a scaling stage that doubles as the output register. One item can be accepted in
// every cycle unless a stalled receiver has let all stages fill.
// Every stage advances on its own when it is empty or the stage after it moves, so
// bubbles are squeezed out and a stalled receiver holds the output steady while the
// earlier stages keep filling; input ready falls only when all 13 stages hold items.
// Reset clears the control points to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_evaluator_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cbez_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cbez_pkg::COORD_BITS-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [cbez_pkg::T_W-1:0]          i_param_t,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [cbez_pkg::COORD_BITS-1:0] o_pos_x,
    output logic signed [cbez_pkg::COORD_BITS-1:0] o_pos_y,
    output logic signed [cbez_pkg::VEL_W-1:0]      o_vel_x,
    output logic signed [cbez_pkg::VEL_W-1:0]      o_vel_y,
    output logic signed [cbez_pkg::ACC_W-1:0]      o_acc_x,
    output logic signed [cbez_pkg::ACC_W-1:0]      o_acc_y
);
    import cbez_pkg::*;

    logic [COORD_BITS-1:0] r_cfg [CFG_NUM];
    logic [NSTG-1:0]       r_v;
    t_stage_en             w_ce;
    t_param                w_t_sat;
    t_coord                w_ctrl_x [4];
    t_coord                w_ctrl_y [4];
    logic                  w_in_acc;
    logic                  w_out_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign w_ctrl_x[0] = $signed(r_cfg[REG_P0_X]);
    assign w_ctrl_x[1] = $signed(r_cfg[REG_P1_X]);
    assign w_ctrl_x[2] = $signed(r_cfg[REG_P2_X]);
    assign w_ctrl_x[3] = $signed(r_cfg[REG_P3_X]);
    assign w_ctrl_y[0] = $signed(r_cfg[REG_P0_Y]);
    assign w_ctrl_y[1] = $signed(r_cfg[REG_P1_Y]);
    assign w_ctrl_y[2] = $signed(r_cfg[REG_P2_Y]);
    assign w_ctrl_y[3] = $signed(r_cfg[REG_P3_Y]);

    assign w_t_sat = (i_param_t > T_ONE) ? T_ONE : i_param_t;

    // A stage loads when it is empty or its item moves on in the same cycle.
    always_comb begin
        w_ce[NSTG-1] = !r_v[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_ce[k] = !r_v[k] || w_ce[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_ce[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_ce[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_in_ready  = w_ce[0];
    assign o_out_valid = r_v[NSTG-1];
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;

    cbez_axis u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_t     (w_t_sat),
        .i_ctrl  (w_ctrl_x),
        .o_pos   (o_pos_x),
        .o_vel   (o_vel_x),
        .o_acc   (o_acc_x)
    );

    cbez_axis u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_t     (w_t_sat),
        .i_ctrl  (w_ctrl_y),
        .o_pos   (o_pos_y),
        .o_vel   (o_vel_y),
        .o_acc   (o_acc_y)
    );

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input is blocked although the output stage is empty.");

    a_blocked_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_v))
        else $error("Input is blocked although a pipeline stage is empty.");

    a_item_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_v) ==
                  $past($countones(r_v)) + int'($past(w_in_acc)) - int'($past(w_out_acc))))
        else $error("An item was lost or duplicated in the pipeline.");

endmodule

`default_nettype wire

>>> tb/tb_cubic_bezier_evaluator_core.sv
// Self-checking testbench for the cubic Bezier evaluator core under random flow control.
`timescale 1ns / 1ps

module tb_cubic_bezier_evaluator_core;
    import cbez_pkg::*;

    typedef struct {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [VEL_W-1:0]      vel_x;
        logic signed [VEL_W-1:0]      vel_y;
        logic signed [ACC_W-1:0]      acc_x;
        logic signed [ACC_W-1:0]      acc_y;
    } t_bez_sample;

    typedef struct {
        longint pos;
        longint vel;
        longint acc;
    } t_axis_eval;

    typedef enum {PTS_FULL, PTS_NEAR, PTS_EXTREME} t_pts_style;

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 200;
    localparam int HOLD_CYCLES   = 80;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_idx  = '0;
    logic [COORD_BITS-1:0]        i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic [T_W-1:0]               i_param_t  = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic signed [COORD_BITS-1:0] o_pos_x;
    logic signed [COORD_BITS-1:0] o_pos_y;
    logic signed [VEL_W-1:0]      o_vel_x;
    logic signed [VEL_W-1:0]      o_vel_y;
    logic signed [ACC_W-1:0]      o_acc_x;
    logic signed [ACC_W-1:0]      o_acc_y;

    t_coord      ctrl_pt [CFG_NUM];
    t_param      t_pending [$];
    t_bez_sample bezier_expected [$];
    bit          sender_idle   = 1'b0;
    bit          receiver_idle = 1'b0;
    int          send_gap      = 0;
    int          recv_wait     = 0;
    int          hold_left     = 0;
    int          results_seen  = 0;
    int          error_count   = 0;

    cubic_bezier_evaluator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_param_t   (i_param_t),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_vel_x     (o_vel_x),
        .o_vel_y     (o_vel_y),
        .o_acc_x     (o_acc_x),
        .o_acc_y     (o_acc_y)
    );

    always #6 i_clk = ~i_clk;

    // Scales d by t in Q1.16, rounding halves away from zero.
    function automatic longint scale_by_param(input longint d, input t_param t);
        longint unsigned mag;
        longint unsigned r;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        r = (mag * longint'(t) + (64'd1 << (T_FRAC_BITS - 1))) >> T_FRAC_BITS;
        return (d < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint lerp_t(input longint a, input longint b, input t_param t);
        return a + scale_by_param(b - a, t);
    endfunction

    function automatic t_axis_eval eval_axis(input longint c0, input longint c1,
                                             input longint c2, input longint c3,
                                             input t_param t);
        t_axis_eval r;
        longint a0, a1, a2, b0, b1, d0, d1, d2, q0, q1;
        a0 = lerp_t(c0, c1, t);
        a1 = lerp_t(c1, c2, t);
        a2 = lerp_t(c2, c3, t);
        b0 = lerp_t(a0, a1, t);
        b1 = lerp_t(a1, a2, t);
        r.pos = lerp_t(b0, b1, t);
        d0 = c1 - c0;
        d1 = c2 - c1;
        d2 = c3 - c2;
        q0 = lerp_t(d0, d1, t);
        q1 = lerp_t(d1, d2, t);
        r.vel = 3 * lerp_t(q0, q1, t);
        r.acc = 6 * lerp_t(d1 - d0, d2 - d1, t);
        return r;
    endfunction

    function automatic t_bez_sample bezier_point(input t_param raw);
        t_param      t;
        t_axis_eval  ex;
        t_axis_eval  ey;
        t_bez_sample s;
        t  = (raw > T_ONE) ? T_ONE : raw;
        ex = eval_axis(ctrl_pt[REG_P0_X], ctrl_pt[REG_P1_X], ctrl_pt[REG_P2_X],
                       ctrl_pt[REG_P3_X], t);
        ey = eval_axis(ctrl_pt[REG_P0_Y], ctrl_pt[REG_P1_Y], ctrl_pt[REG_P2_Y],
                       ctrl_pt[REG_P3_Y], t);
        s.pos_x = COORD_BITS'(ex.pos);
        s.pos_y = COORD_BITS'(ey.pos);
        s.vel_x = VEL_W'(ex.vel);
        s.vel_y = VEL_W'(ey.vel);
        s.acc_x = ACC_W'(ex.acc);
        s.acc_y = ACC_W'(ey.acc);
        return s;
    endfunction

    function automatic t_param random_param();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return T_ONE;
        if (pick == 1)
            return '0;
        if (pick <= 3)
            return T_W'($urandom_range(T_ONE + 1, 2 ** T_W - 1));
        return T_W'($urandom_range(0, T_ONE));
    endfunction

    function automatic t_coord random_coord(input t_pts_style style);
        case (style)
            PTS_FULL: return t_coord'($urandom);
            PTS_NEAR: return t_coord'($urandom_range(0, 1 << 22) - (1 << 21));
            default: begin
                case ($urandom_range(0, 4))
                    0: return {1'b0, {(COORD_BITS - 1){1'b1}}};
                    1: return {1'b1, {(COORD_BITS - 1){1'b0}}};
                    2: return '0;
                    3: return '1;
                    default: return t_coord'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic load_points(input t_coord pt [CFG_NUM]);
        for (int i = 0; i < CFG_NUM; i++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= pt[i];
            ctrl_pt[i] = pt[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (t_pending.size() != 0 || i_in_valid || bezier_expected.size() != 0);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            error_count++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready)
                bezier_expected.push_back(bezier_point(i_param_t));
            if (i_in_valid && !o_in_ready) begin
                i_in_valid <= 1'b1;
            end else if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap--;
            end else if (t_pending.size() > 0) begin
                i_param_t  <= t_pending.pop_front();
                i_in_valid <= 1'b1;
                send_gap = sender_idle ? $urandom_range(0, 3) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_bez_sample want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (bezier_expected.size() == 0) begin
                    error_count++;
                    $error("result item arrived with no expectation pending");
                end else begin
                    want = bezier_expected.pop_front();
                    check_field("pos_x", want.pos_x, o_pos_x);
                    check_field("pos_y", want.pos_y, o_pos_y);
                    check_field("vel_x", want.vel_x, o_vel_x);
                    check_field("vel_y", want.vel_y, o_vel_y);
                    check_field("acc_x", want.acc_x, o_acc_x);
                    check_field("acc_y", want.acc_y, o_acc_y);
                end
                results_seen++;
                // Long hold-offs let the pipeline fill so that input ready drops.
                if (results_seen == 300 || results_seen == 900)
                    hold_left = HOLD_CYCLES;
                else
                    recv_wait = receiver_idle ? $urandom_range(0, 3) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_coord      pts [CFG_NUM];
        int unsigned corner_t [8];
        t_pts_style  style;
        corner_t = '{0, 1, 16384, 32768, 65535, 65536, 65537, 131071};
        for (int i = 0; i < CFG_NUM; i++)
            ctrl_pt[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Corner parameters under the reset points, full-scale alternation and odd
        // values that produce exact rounding ties at one half.
        for (int c = 0; c < 3; c++) begin
            if (c == 1) begin
                pts[REG_P0_X] = {1'b1, {(COORD_BITS - 1){1'b0}}};
                pts[REG_P1_X] = {1'b0, {(COORD_BITS - 1){1'b1}}};
                pts[REG_P2_X] = {1'b1, {(COORD_BITS - 1){1'b0}}};
                pts[REG_P3_X] = {1'b0, {(COORD_BITS - 1){1'b1}}};
                pts[REG_P0_Y] = {1'b0, {(COORD_BITS - 1){1'b1}}};
                pts[REG_P1_Y] = {1'b1, {(COORD_BITS - 1){1'b0}}};
                pts[REG_P2_Y] = {1'b0, {(COORD_BITS - 1){1'b1}}};
                pts[REG_P3_Y] = {1'b1, {(COORD_BITS - 1){1'b0}}};
                load_points(pts);
            end else if (c == 2) begin
                pts[REG_P0_X] = 1;
                pts[REG_P1_X] = -2;
                pts[REG_P2_X] = 5;
                pts[REG_P3_X] = -7;
                pts[REG_P0_Y] = -3;
                pts[REG_P1_Y] = 4;
                pts[REG_P2_Y] = -1;
                pts[REG_P3_Y] = {1'b0, {(COORD_BITS - 1){1'b1}}};
                load_points(pts);
            end
            sender_idle   = (c == 1);
            receiver_idle = (c == 2);
            foreach (corner_t[k])
                t_pending.push_back(T_W'(corner_t[k]));
            wait_drained();
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            style = t_pts_style'(ph % 3);
            for (int i = 0; i < CFG_NUM; i++)
                pts[i] = random_coord(style);
            load_points(pts);
            sender_idle   = (ph % 3) != 0;
            receiver_idle = (ph % 2) != 0;
            repeat (PHASE_ITEMS)
                t_pending.push_back(random_param());
            wait_drained();
        end

        repeat (2 * NSTG) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_cubic_bezier_evaluator_core OK");
        else
            $display("tb_cubic_bezier_evaluator_core NOT OK");
        $finish;
    end

    initial begin
        #5000000;
        $display("tb_cubic_bezier_evaluator_core NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
hdl/cbez_pkg.sv
hdl/cbez_axis.sv
hdl/cubic_bezier_evaluator_core.sv
tb/tb_cubic_bezier_evaluator_core.sv
